// ----- rtl/core/mrmp_pkg.sv -----
// Shared constants and types for the modular recurrence matrix power core.
`default_nettype none
package mrmp_pkg;
  localparam int unsigned RES_W = 30;
  localparam int unsigned SYM_W = 63;
  localparam logic [RES_W-1:0] PRIME = 30'd1000000007;
  localparam logic [RES_W-1:0] PRIME_M1 = 30'd1000000006;
  typedef logic [RES_W-1:0] residue_t;

  // (a + b) mod P for a, b < P
  function automatic residue_t mod_add(input residue_t a, input residue_t b);
    logic [RES_W:0] s;
    logic [RES_W:0] d;
    begin
      s = {1'b0, a} + {1'b0, b};
      d = s - {1'b0, PRIME};
      mod_add = d[RES_W] ? s[RES_W-1:0] : d[RES_W-1:0];
    end
  endfunction

  // (2a + bit) mod P for a < P
  function automatic residue_t mod_dbl(input residue_t a, input logic b);
    logic [RES_W:0] s;
    logic [RES_W:0] d;
    begin
      s = {a, b};
      d = s - {1'b0, PRIME};
      mod_dbl = d[RES_W] ? s[RES_W-1:0] : d[RES_W-1:0];
    end
  endfunction
endpackage
`default_nettype wire

// ----- rtl/core/mrmp_mulmod.sv -----
// Bit-serial modular multiplier: one multiplier bit per cycle, MSB first.
`default_nettype none
module mrmp_mulmod
  import mrmp_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     go,
  input  wire residue_t a,
  input  wire residue_t b,
  output logic          done,
  output residue_t      p
);
  residue_t acc;
  residue_t mb;
  residue_t ma;
  logic [4:0] cnt;
  logic run;

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run <= 1'b1;
        cnt <= 5'(RES_W - 1);
        acc <= '0;
        ma <= a;
        mb <= b;
      end else if (run) begin
        mb <= {mb[RES_W-2:0], 1'b0};
        if (cnt == 5'd0) begin
          run <= 1'b0;
          done <= 1'b1;
          p <= mod_add(mod_dbl(acc, 1'b0), mb[RES_W-1] ? ma : '0);
        end else begin
          acc <= mod_add(mod_dbl(acc, 1'b0), mb[RES_W-1] ? ma : '0);
          cnt <= cnt - 5'd1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ----- rtl/core/modular_recurrence_matrix_power_core.sv -----
// Top level: sequencer for the 2x2 modular matrix power recurrence.
`default_nettype none
// Takes one item (length, symbols) when start is high and busy is low, and
// returns count = a(n) mod 1000000007 in the first cycle in which busy is low
// again, flagged by done for that single cycle; the receiver cannot stall, so
// the result must be captured on that cycle. Symbols is reduced bit-serially,
// one input bit per cycle. All products go through one bit-serial modular
// multiplier. For n >= 3 every exponent bit of n-2 costs a bit test, one
// matrix square (8 products) and, for a one bit, one matrix product (8
// products); one more bit test ends the loop. The square of m and the final
// combine cost 3 products. With LENGTH_BITS = 63 the exponent has at most
// 63 bits, at most 62 of them ones.
module modular_recurrence_matrix_power_core
  import mrmp_pkg::*;
#(
  parameter int unsigned LENGTH_BITS = 63
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  input  wire logic [LENGTH_BITS-1:0] length,
  input  wire logic [SYM_W-1:0]       symbols,
  output logic                        busy,
  output logic                        done,
  output logic [RES_W-1:0]            count
);
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RED  = 4'd1;
  localparam logic [3:0] S_MSQ  = 4'd2;
  localparam logic [3:0] S_BIT  = 4'd3;
  localparam logic [3:0] S_MUL  = 4'd4;
  localparam logic [3:0] S_SQR  = 4'd5;
  localparam logic [3:0] S_FIN  = 4'd6;
  localparam logic [3:0] S_OUT  = 4'd7;
  localparam int unsigned CW = $clog2(SYM_W + 1);

  logic [3:0] state;
  logic [SYM_W-1:0] sym_sh;
  logic [CW-1:0] bcnt;
  logic [LENGTH_BITS-1:0] e;
  logic [LENGTH_BITS-1:0] n;
  residue_t m, msq, t0;
  residue_t c00, c01, c10, c11; // accumulator
  residue_t b00, b01, b10, b11; // base
  residue_t r00, r01, r10, r11;
  logic [2:0] k;       // product index within a matrix multiply
  logic wait_mul;
  logic go;
  residue_t ma, mb, mp;
  logic mdone;

  mrmp_mulmod u_mul (
    .clk(clk), .rst(rst), .go(go), .a(ma), .b(mb), .done(mdone), .p(mp)
  );

  // Left operand rows: accumulator for multiply, base for square.
  residue_t l0, l1, q0, q1;
  always_comb begin
    residue_t p00, p01, p10, p11;
    p00 = (state == S_MUL) ? c00 : b00;
    p01 = (state == S_MUL) ? c01 : b01;
    p10 = (state == S_MUL) ? c10 : b10;
    p11 = (state == S_MUL) ? c11 : b11;
    // product k: row k[2], col k[1], term k[0]
    l0 = k[2] ? p10 : p00;
    l1 = k[2] ? p11 : p01;
    q0 = k[1] ? b01 : b00;
    q1 = k[1] ? b11 : b10;
    ma = '0;
    mb = '0;
    unique case (state)
      S_MSQ: begin
        ma = m;
        mb = m;
      end
      S_FIN: begin
        ma = k[0] ? c01 : c00;
        mb = k[0] ? m : msq;
      end
      default: begin
        ma = k[0] ? l1 : l0;
        mb = k[0] ? q1 : q0;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
      go <= 1'b0;
      wait_mul <= 1'b0;
    end else begin
      done <= 1'b0;
      go <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            n <= length;
            sym_sh <= symbols;
            m <= '0;
            bcnt <= CW'(SYM_W);
            state <= S_RED;
          end
        end
        S_RED: begin
          // Horner reduction, one input bit per cycle
          m <= mod_dbl(m, sym_sh[SYM_W-1]);
          sym_sh <= {sym_sh[SYM_W-2:0], 1'b0};
          bcnt <= bcnt - CW'(1);
          if (bcnt == CW'(1)) begin
            state <= S_MSQ;
            go <= 1'b1;
            wait_mul <= 1'b1;
          end
        end
        S_MSQ: begin
          if (mdone) begin
            msq <= mp;
            wait_mul <= 1'b0;
            if (n == LENGTH_BITS'(1)) begin
              count <= m;
              state <= S_OUT;
            end else if (n <= LENGTH_BITS'(2)) begin
              count <= mp;
              state <= S_OUT;
            end else begin
              e <= n - LENGTH_BITS'(2);
              c00 <= residue_t'(1); c01 <= '0; c10 <= '0; c11 <= residue_t'(1);
              b00 <= (m == '0) ? PRIME_M1 : m - residue_t'(1);
              b01 <= (m == '0) ? PRIME_M1 : m - residue_t'(1);
              b10 <= residue_t'(1); b11 <= '0;
              state <= S_BIT;
            end
          end
        end
        S_BIT: begin
          k <= '0;
          go <= 1'b1;
          wait_mul <= 1'b1;
          if (e == '0) begin
            state <= S_FIN;
          end else if (e[0]) begin
            state <= S_MUL;
          end else begin
            state <= S_SQR;
          end
        end
        S_MUL, S_SQR: begin
          if (mdone) begin
            if (!k[0]) begin
              t0 <= mp;
            end else begin
              unique case (k[2:1])
                2'd0: r00 <= mod_add(t0, mp);
                2'd1: r01 <= mod_add(t0, mp);
                2'd2: r10 <= mod_add(t0, mp);
                default: r11 <= mod_add(t0, mp);
              endcase
            end
            if (k == 3'd7) begin
              if (state == S_MUL) begin
                // square follows at once, multiplier stays claimed
                c00 <= r00; c01 <= r01; c10 <= r10; c11 <= mod_add(t0, mp);
                state <= S_SQR;
                k <= '0;
                go <= 1'b1;
              end else begin
                wait_mul <= 1'b0;
                b00 <= r00; b01 <= r01; b10 <= r10; b11 <= mod_add(t0, mp);
                e <= e >> 1;
                state <= S_BIT;
              end
            end else begin
              k <= k + 3'd1;
              go <= 1'b1;
            end
          end
        end
        S_FIN: begin
          if (mdone) begin
            if (!k[0]) begin
              t0 <= mp;
              k <= 3'd1;
              go <= 1'b1;
            end else begin
              wait_mul <= 1'b0;
              count <= mod_add(t0, mp);
              state <= S_OUT;
            end
          end
        end
        S_OUT: begin
          done <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> (state == S_IDLE)) else $error("done outside idle");
  a_out_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (count < PRIME)) else $error("count not reduced");
  a_mul_wait: assert property (@(posedge clk) disable iff (rst)
    mdone |-> wait_mul) else $error("stray multiplier result");
endmodule
`default_nettype wire
